@@ design/yuvrgb_pkg.sv @@
// Shared types, coefficients and helpers for the YUV 4:2:0 block to RGB24 converter.
// No dependencies.
package yuvrgb_pkg;

    localparam int SAMPLE_W = 8;
    localparam int OFF_W    = 9;   // sample minus its bias, signed
    localparam int COEF_W   = 19;  // largest coefficient needs 18 bits plus sign
    localparam int SUM_W    = 28;  // widest product or sum, signed
    localparam int FRAC_W   = 16;
    localparam int PIX_W    = 3 * SAMPLE_W;

    // BT.601, 16.16 fixed point
    localparam logic signed [COEF_W-1:0] LUMA_GAIN   = 19'sd76309;
    localparam logic signed [COEF_W-1:0] CR_TO_RED   = 19'sd104597;
    localparam logic signed [COEF_W-1:0] CB_TO_BLUE  = 19'sd132201;
    localparam logic signed [COEF_W-1:0] CB_TO_GREEN = 19'sd25675;
    localparam logic signed [COEF_W-1:0] CR_TO_GREEN = 19'sd53279;
    localparam logic signed [OFF_W-1:0]  LUMA_BASE   = 9'sd16;
    localparam logic signed [OFF_W-1:0]  CHROMA_MID  = 9'sd128;

    typedef logic signed [OFF_W-1:0] off_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [SAMPLE_W-1:0]     sample_t;

    // load enables of the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    function automatic off_t remove_bias(input sample_t x, input off_t bias);
        off_t ext;
        ext = $signed({1'b0, x});
        return ext - bias;
    endfunction

    function automatic sum_t mul_coef(input off_t x, input logic signed [COEF_W-1:0] c);
        sum_t xe;
        sum_t ce;
        xe = SUM_W'(x);
        ce = SUM_W'(c);
        return xe * ce;
    endfunction

    // floor shift by the fraction width, then limit to 0..255
    function automatic sample_t clamp_shift(input sum_t s);
        sample_t q;
        if (s[SUM_W-1]) begin
            q = '0;
        end else if (|s[SUM_W-2:FRAC_W+SAMPLE_W]) begin
            q = '1;
        end else begin
            q = s[FRAC_W+SAMPLE_W-1:FRAC_W];
        end
        return q;
    endfunction

endpackage

@@ design/yuv420_block_to_rgb24_fixed_unit.sv @@
// Top level of the YUV 4:2:0 2x2 block to RGB24 converter (BT.601, 16.16 fixed point).
// Depends on yuvrgb_pkg and yuvrgb_pixel.
//
//  port group   dir  payload
//  s_*          in   one 2x2 block: four luma samples, shared U and V
//  m_*          out  four RGB24 pixels of that block
//
// Four stages: bias removal, constant multiplies, sums, shift and clamp.
// One item per cycle while m_tready holds; an accepted item passes the stage 1 to 4
// registers in order, and m_tvalid rises when it reaches stage 4.
// Each stage loads when it is empty or the next one moves, so bubbles close up
// during an output stall and nothing is lost or repeated.
// Reset clears only the stage valid bits.
module yuv420_block_to_rgb24_fixed_unit import yuvrgb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    // chroma_blue, chroma_red (8 bits each)
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red, green, blue of top_left, top_right, bottom_left, bottom_right (8 bits each)
    output logic [95:0] m_tdata
);

    localparam int NUM_PIX = 4;

    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      v1_next, v2_next, v3_next, v4_next;
    logic      rdy1, rdy2, rdy3, rdy4;
    stage_en_t en;

    off_t y_off_reg [NUM_PIX];
    off_t u_off_reg;
    off_t v_off_reg;
    sum_t cr_reg, cb_reg, gu_reg, gv_reg;

    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    always_comb begin
        en.s1 = rdy1;
        en.s2 = rdy2;
        en.s3 = rdy3;
        en.s4 = rdy4;
        v1_next = rdy1 ? s_tvalid : v1_reg;
        v2_next = rdy2 ? v1_reg   : v2_reg;
        v3_next = rdy3 ? v2_reg   : v3_reg;
        v4_next = rdy4 ? v3_reg   : v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            for (int k = 0; k < NUM_PIX; k++) begin
                y_off_reg[k] <= remove_bias(s_tdata[k*SAMPLE_W +: SAMPLE_W], LUMA_BASE);
            end
            u_off_reg <= remove_bias(s_tdata[4*SAMPLE_W +: SAMPLE_W], CHROMA_MID);
            v_off_reg <= remove_bias(s_tdata[5*SAMPLE_W +: SAMPLE_W], CHROMA_MID);
        end
        if (en.s2) begin
            cr_reg <= mul_coef(v_off_reg, CR_TO_RED);
            cb_reg <= mul_coef(u_off_reg, CB_TO_BLUE);
            gu_reg <= mul_coef(u_off_reg, CB_TO_GREEN);
            gv_reg <= mul_coef(v_off_reg, CR_TO_GREEN);
        end
    end

    for (genvar g = 0; g < NUM_PIX; g++) begin : g_pix
        yuvrgb_pixel u_pix (
            .aclk    (aclk),
            .en      (en),
            .y_off   (y_off_reg[g]),
            .cr_prod (cr_reg),
            .cb_prod (cb_reg),
            .gu_prod (gu_reg),
            .gv_prod (gv_reg),
            .rgb     (m_tdata[g*PIX_W +: PIX_W])
        );
    end

    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !v1_reg)
        else $error("pipeline not empty after reset");

    // a pipe that is not full always takes an item
    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !(v1_reg && v2_reg && v3_reg && v4_reg) |-> s_tready)
        else $error("input stalled with free stage");

    // an accepted item lands in stage 1
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted item lost at stage 1");

    // a draining output never backs up the input
    a_flow_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // a stalled result holds its value
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed under stall");

endmodule

@@ design/yuvrgb_pixel.sv @@
// One pixel lane: luma scaling, color sums and clamping across stages 2 to 4.
// Depends on yuvrgb_pkg; chroma products come from the top level.
module yuvrgb_pixel import yuvrgb_pkg::*; (
    input  logic      aclk,
    input  stage_en_t en,
    input  off_t      y_off,      // stage 1 register, luma minus 16
    input  sum_t      cr_prod,    // stage 2 registers
    input  sum_t      cb_prod,
    input  sum_t      gu_prod,
    input  sum_t      gv_prod,
    output logic [PIX_W-1:0] rgb  // red, green, blue from the lowest bit up
);

    sum_t ys_reg;
    sum_t r_sum_reg;
    sum_t g_sum_reg;
    sum_t b_sum_reg;
    logic [PIX_W-1:0] rgb_reg;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            ys_reg <= mul_coef(y_off, LUMA_GAIN);
        end
        if (en.s3) begin
            r_sum_reg <= ys_reg + cr_prod;
            g_sum_reg <= ys_reg - gu_prod - gv_prod;
            b_sum_reg <= ys_reg + cb_prod;
        end
        if (en.s4) begin
            rgb_reg <= {clamp_shift(b_sum_reg), clamp_shift(g_sum_reg), clamp_shift(r_sum_reg)};
        end
    end

    assign rgb = rgb_reg;

endmodule

@@ bench/tb_yuv420_block_to_rgb24_fixed_unit.sv @@
// Self-checking bench for yuv420_block_to_rgb24_fixed_unit: 2x2 YUV 4:2:0 blocks in, RGB24 out.
// Depends on yuvrgb_pkg (coefficients) and the converter RTL; a local predictor gives the
// expected pixels, checked in order under random idling and long output stalls.
module tb_yuv420_block_to_rgb24_fixed_unit import yuvrgb_pkg::*;;

    localparam int LIMIT_CYCLES = 200000;
    localparam int STALL_CYCLES = 80;
    localparam int TAIL_CYCLES  = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    // chroma_blue, chroma_red (8 bits each)
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // red, green, blue of top_left, top_right, bottom_left, bottom_right (8 bits each)
    logic [95:0] m_tdata;

    logic        idle_en    = 1'b0;
    logic        hold_start = 1'b0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          mismatch_count = 0;
    logic [95:0] rgb_expected [$];

    string field_names [12] = '{
        "red_top_left", "green_top_left", "blue_top_left",
        "red_top_right", "green_top_right", "blue_top_right",
        "red_bottom_left", "green_bottom_left", "blue_bottom_left",
        "red_bottom_right", "green_bottom_right", "blue_bottom_right"
    };

    yuv420_block_to_rgb24_fixed_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // floor shift out the fraction, then saturate to a sample
    function automatic logic [7:0] saturate_component(input longint acc);
        longint q;
        q = acc >>> FRAC_W;
        if (q < 0) begin
            return 8'd0;
        end
        if (q > 255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    function automatic logic [95:0] convert_block(input logic [47:0] blk);
        longint      u;
        longint      v;
        longint      ys;
        longint      luma;
        logic [95:0] rgb;
        u = blk[39:32];
        v = blk[47:40];
        u = u - CHROMA_MID;
        v = v - CHROMA_MID;
        for (int k = 0; k < 4; k++) begin
            luma = blk[k*8 +: 8];
            ys = LUMA_GAIN * (luma - LUMA_BASE);
            rgb[k*24 +: 8]      = saturate_component(ys + CR_TO_RED * v);
            rgb[k*24 + 8 +: 8]  = saturate_component(ys - CB_TO_GREEN * u - CR_TO_GREEN * v);
            rgb[k*24 + 16 +: 8] = saturate_component(ys + CB_TO_BLUE * u);
        end
        return rgb;
    endfunction

    function automatic logic [47:0] pack_block(input logic [7:0] tl, input logic [7:0] tr,
                                               input logic [7:0] bl, input logic [7:0] br,
                                               input logic [7:0] u, input logic [7:0] v);
        return {v, u, br, bl, tr, tl};
    endfunction

    // mostly uniform samples, with the bias points and rails mixed in
    function automatic logic [47:0] random_block();
        logic [47:0] blk;
        for (int k = 0; k < 6; k++) begin
            case ($urandom_range(0, 9))
                0: blk[k*8 +: 8] = 8'd0;
                1: blk[k*8 +: 8] = 8'd255;
                2: blk[k*8 +: 8] = (k < 4) ? 8'd16 : 8'd128;
                default: blk[k*8 +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return blk;
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_block(input logic [47:0] blk);
        if (idle_en) begin
            while ($urandom_range(0, 99) < 9) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        @(negedge aclk);
        while (!s_tready) begin
            @(negedge aclk);
        end
        rgb_expected.push_back(convert_block(blk));
        @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (rgb_expected.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // receiver: random idling, plus a long hold when requested
    always @(posedge aclk) begin
        if (hold_start && stall_left == 0) begin
            stall_left <= STALL_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_en && $urandom_range(0, 99) < 9) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // signals settle by the falling edge and hold until the next rising one
    always @(negedge aclk) begin
        logic [95:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (rgb_expected.size() == 0) begin
                $display("%0t: unexpected item expected none actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = rgb_expected.pop_front();
                for (int k = 0; k < 12; k++) begin
                    if (m_tdata[k*8 +: 8] !== want[k*8 +: 8]) begin
                        $display("%0t: %s expected %0d actual %0d", $time, field_names[k],
                                 want[k*8 +: 8], m_tdata[k*8 +: 8]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        idle_en <= 1'b1;
        send_block(pack_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_block(pack_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_block(pack_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128));
        send_block(pack_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128));
        send_block(pack_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd128, 8'd128));
        send_block(pack_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd0, 8'd0));
        send_block(pack_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd255, 8'd255));
        send_block(pack_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd0, 8'd255));
        send_block(pack_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd255, 8'd0));
        send_block(pack_block(8'd255, 8'd170, 8'd85, 8'd0, 8'd0, 8'd128));
        send_block(pack_block(8'd255, 8'd170, 8'd85, 8'd0, 8'd255, 8'd128));
        send_block(pack_block(8'd255, 8'd170, 8'd85, 8'd0, 8'd128, 8'd0));
        send_block(pack_block(8'd255, 8'd170, 8'd85, 8'd0, 8'd128, 8'd255));
        // sums landing right at the rails
        send_block(pack_block(8'd17, 8'd15, 8'd234, 8'd236, 8'd129, 8'd127));
        send_block(pack_block(8'd17, 8'd15, 8'd234, 8'd236, 8'd127, 8'd129));
        send_block(pack_block(8'd16, 8'd240, 8'd30, 8'd200, 8'd1, 8'd254));
        send_block(pack_block(8'd16, 8'd240, 8'd30, 8'd200, 8'd254, 8'd1));
        send_block(pack_block(8'd1, 8'd254, 8'd128, 8'd127, 8'd64, 8'd192));
        send_block(pack_block(8'd1, 8'd254, 8'd128, 8'd127, 8'd192, 8'd64));
        send_block(pack_block(8'haa, 8'h55, 8'h0f, 8'hf0, 8'haa, 8'h55));
        send_block(pack_block(8'h55, 8'haa, 8'hf0, 8'h0f, 8'h55, 8'haa));
        wait_for_results();
    endtask

    task automatic test_random_with_idling(input int count);
        idle_en <= 1'b1;
        for (int i = 0; i < count; i++) begin
            send_block(random_block());
        end
        wait_for_results();
    endtask

    task automatic test_continuous_stream(input int count);
        idle_en <= 1'b0;
        @(posedge aclk);
        for (int i = 0; i < count; i++) begin
            send_block(random_block());
        end
        wait_for_results();
    endtask

    // long output hold while input keeps coming: pipeline fills, input stalls
    task automatic test_output_stall_fill(input int count);
        idle_en    <= 1'b0;
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        for (int i = 0; i < count; i++) begin
            send_block(random_block());
        end
        wait_for_results();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_random_with_idling(500);
        test_continuous_stream(300);
        test_output_stall_fill(40);
        test_random_with_idling(700);
        test_output_stall_fill(20);
        idle_en <= 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && rgb_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
